// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of the list engine.
// Include guard below; only plain property wrappers live here.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define BOLE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset.
`define BOLE_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/bole_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
// No dependencies; used by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package bole_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 3'd0,
        ACT_POP     = 3'd1,
        ACT_REMOVE  = 3'd2,
        ACT_SEARCH  = 3'd3,
        ACT_REVERSE = 3'd4,
        ACT_QUERY   = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // pointer updates; read ports sample the updated pointers
    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_INS_INIT,
        PTR_RM_INIT,
        PTR_SR_INIT,
        PTR_RV_INIT,
        PTR_INC,
        PTR_DEC,
        PTR_RV_STEP
    } t_ptr_op;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INS_MOVE,
        WR_INS_PUT,
        WR_RM_MOVE,
        WR_RV_LO,
        WR_RV_HI
    } t_wr_op;

    typedef struct packed {
        logic    load;
        t_ptr_op ptr;
        logic    rd_en;
        t_wr_op  wr;
        logic    set_found;
        logic    finish;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        t_status pre_status;
        logic    empty;
        logic    ins_direct;
        logic    ins_last;
        logic    rm_direct;
        logic    rm_last;
        logic    sr_match;
        logic    sr_last;
        logic    rv_none;
        logic    rv_last;
    } t_dp_flags;

endpackage

// ----- sv/bounded_ordered_list_engine_core.sv -----
// Top level of the bounded ordered list engine.
// Instantiates bole_ctrl and bole_dp; types from bole_pkg.
`timescale 1ns / 1ps

// Usage
//  Request channel: drive i_action, i_value, i_position and raise start;
//  the request is taken at a rising edge where start is high and busy low.
//  busy stays high from that edge until the result goes out.
//  Result channel: o_done strobes for exactly one cycle with o_status,
//  o_found, o_match_index and o_element_count; the receiver cannot stall
//  it, so capture on the strobe. A new request may be issued in the strobe
//  cycle (busy is already low then).
//  Steps from the accepting edge to the strobe:
//    query, pop, unused codes, rejected requests: decode, then finish
//    search: entries are compared in order up to the first match
//    insert: entries at or after position shift up, then the value is put;
//    remove: entries after position shift down; reverse: halves swap pairwise
//  The entry memory has one write port, so every shift or half swap is
//  a write step of its own.
//  Reset (synchronous, active low) empties the list and idles the
//  controller; entry contents are not cleared, and slots at or beyond the
//  count are never used in a result.
module bounded_ordered_list_engine_core #(
    parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic [bole_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [bole_pkg::VALUE_W-1:0]  i_value,
    input  logic [bole_pkg::POS_W-1:0]           i_position,
    output logic                                 busy,
    output logic                                 o_done,
    output logic [bole_pkg::STATUS_W-1:0]        o_status,
    output logic                                 o_found,
    output logic [bole_pkg::INDEX_W-1:0]         o_match_index,
    output logic [bole_pkg::COUNT_W-1:0]         o_element_count
);
    import bole_pkg::*;

    // command and status bundles between controller and datapath
    t_dp_cmd   w_cmd;
    t_dp_flags w_flags;
    t_status   w_status;

    bole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (w_flags),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // entries, count and result registers live here
    bole_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_action        (i_action),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_flags         (w_flags),
        .o_status        (w_status),
        .o_found         (o_found),
        .o_match_index   (o_match_index),
        .o_element_count (o_element_count),
        .o_done          (o_done)
    );

    assign o_status = w_status;

endmodule

// ----- sv/bole_dp.sv -----
// Datapath of the list engine: entry memory, count, walk pointers, result registers.
// Depends on bole_pkg; driven by bole_ctrl through t_dp_cmd.
`timescale 1ns / 1ps

module bole_dp #(
    parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bole_pkg::t_dp_cmd                    i_cmd,
    input  logic [bole_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [bole_pkg::VALUE_W-1:0]  i_value,
    input  logic [bole_pkg::POS_W-1:0]           i_position,
    output bole_pkg::t_dp_flags                  o_flags,
    output bole_pkg::t_status                    o_status,
    output logic                                 o_found,
    output logic [bole_pkg::INDEX_W-1:0]         o_match_index,
    output logic [bole_pkg::COUNT_W-1:0]         o_element_count,
    output logic                                 o_done
);
    import bole_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [VALUE_W-1:0] r_mem [DEPTH];

    logic [ACTION_W-1:0] r_action;
    logic [VALUE_W-1:0]  r_value;
    logic [POS_W-1:0]    r_pos;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [AW-1:0]       r_p;
    logic [AW-1:0]       n_p;
    logic [AW-1:0]       r_q;
    logic [AW-1:0]       n_q;
    logic [VALUE_W-1:0]  r_rd_a;
    logic [VALUE_W-1:0]  r_rd_b;
    logic                r_found;
    logic [AW-1:0]       r_idx;
    t_status             r_status;
    logic                r_done;

    t_action             w_act;
    t_status             w_pre_status;
    logic [PW:0]         w_pos;
    logic [PW:0]         w_cnt;
    logic                w_p_at_end;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [VALUE_W-1:0]  w_wdata;

    assign w_act = t_action'(r_action);
    assign w_pos = (PW+1)'(r_pos);
    assign w_cnt = (PW+1)'(r_count);
    // pointer is the last live entry
    assign w_p_at_end = ((CW'(r_p) + CW'(1)) == r_count);

    // status is fixed by action, position and count before any entry moves
    always_comb begin
        w_pre_status = ST_OK;
        unique case (w_act)
            ACT_INSERT: begin
                if (w_cnt >= (PW+1)'(DEPTH)) begin
                    w_pre_status = ST_FULL;
                end else if (w_pos > w_cnt) begin
                    w_pre_status = ST_BADPOS;
                end
            end
            ACT_POP: begin
                if (r_count == '0) begin
                    w_pre_status = ST_EMPTY;
                end
            end
            ACT_REMOVE: begin
                if (r_count == '0 && r_pos == '0) begin
                    w_pre_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_pre_status = ST_BADPOS;
                end
            end
            default: begin
                w_pre_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        o_flags.action     = w_act;
        o_flags.pre_status = w_pre_status;
        o_flags.empty      = (r_count == '0);
        o_flags.ins_direct = (w_pos == w_cnt);
        o_flags.ins_last   = (r_p == AW'(r_pos));
        o_flags.rm_direct  = ((w_pos + (PW+1)'(1)) == w_cnt);
        o_flags.rm_last    = w_p_at_end;
        o_flags.sr_match   = (r_rd_a == r_value);
        o_flags.sr_last    = w_p_at_end;
        o_flags.rv_none    = (r_count <= CW'(1));
        o_flags.rv_last    = (((AW+1)'(r_p) + (AW+1)'(2)) >= (AW+1)'(r_q));
    end

    always_comb begin
        n_p = r_p;
        n_q = r_q;
        unique case (i_cmd.ptr)
            PTR_HOLD: begin
                n_p = r_p;
            end
            PTR_INS_INIT: begin
                n_p = AW'(r_count - CW'(1));
            end
            PTR_RM_INIT: begin
                n_p = AW'(r_pos) + AW'(1);
            end
            PTR_SR_INIT: begin
                n_p = '0;
            end
            PTR_RV_INIT: begin
                n_p = '0;
                n_q = AW'(r_count - CW'(1));
            end
            PTR_INC: begin
                n_p = r_p + AW'(1);
            end
            PTR_DEC: begin
                n_p = r_p - AW'(1);
            end
            PTR_RV_STEP: begin
                n_p = r_p + AW'(1);
                n_q = r_q - AW'(1);
            end
        endcase
    end

    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_p;
        w_wdata = r_rd_a;
        unique case (i_cmd.wr)
            WR_INS_MOVE: begin
                w_waddr = r_p + AW'(1);
            end
            WR_INS_PUT: begin
                w_waddr = AW'(r_pos);
                w_wdata = r_value;
            end
            WR_RM_MOVE: begin
                w_waddr = r_p - AW'(1);
            end
            WR_RV_LO: begin
                w_wdata = r_rd_b;
            end
            WR_RV_HI: begin
                w_waddr = r_q;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.finish && w_pre_status == ST_OK) begin
            unique case (w_act)
                ACT_INSERT: begin
                    n_count = r_count + CW'(1);
                end
                ACT_POP, ACT_REMOVE: begin
                    n_count = r_count - CW'(1);
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem[n_p];
            r_rd_b <= r_mem[n_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_q <= n_q;
        if (i_cmd.load) begin
            r_action <= i_action;
            r_value  <= i_value;
            r_pos    <= i_position;
            r_found  <= 1'b0;
            r_idx    <= '0;
        end
        if (i_cmd.set_found) begin
            r_found <= 1'b1;
            r_idx   <= r_p;
        end
        if (i_cmd.finish) begin
            r_status <= w_pre_status;
        end
    end

    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_match_index   = INDEX_W'(r_idx);
    assign o_element_count = COUNT_W'(r_count);
    assign o_done          = r_done;

endmodule

// ----- sv/bole_ctrl.sv -----
// Controller of the list engine: sequences each request over the datapath.
// Depends on bole_pkg; talks to bole_dp through t_dp_cmd / t_dp_flags.
`timescale 1ns / 1ps

module bole_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  bole_pkg::t_dp_flags i_flags,
    output bole_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);
    import bole_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_MV,
        S_INS_PUT,
        S_RM_MV,
        S_SR_CMP,
        S_RV_WLO,
        S_RV_WHI,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    always_comb begin
        n_state         = r_state;
        n_busy          = r_busy;
        o_cmd.load      = 1'b0;
        o_cmd.ptr       = PTR_HOLD;
        o_cmd.rd_en     = 1'b0;
        o_cmd.wr        = WR_NONE;
        o_cmd.set_found = 1'b0;
        o_cmd.finish    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                    n_busy     = 1'b1;
                end
            end
            S_DECODE: begin
                priority if (i_flags.pre_status != ST_OK) begin
                    n_state = S_FINISH;
                end else begin
                    unique case (i_flags.action)
                        ACT_INSERT: begin
                            if (i_flags.ins_direct) begin
                                n_state = S_INS_PUT;
                            end else begin
                                o_cmd.ptr   = PTR_INS_INIT;
                                o_cmd.rd_en = 1'b1;
                                n_state     = S_INS_MV;
                            end
                        end
                        ACT_REMOVE: begin
                            if (i_flags.rm_direct) begin
                                n_state = S_FINISH;
                            end else begin
                                o_cmd.ptr   = PTR_RM_INIT;
                                o_cmd.rd_en = 1'b1;
                                n_state     = S_RM_MV;
                            end
                        end
                        ACT_SEARCH: begin
                            if (i_flags.empty) begin
                                n_state = S_FINISH;
                            end else begin
                                o_cmd.ptr   = PTR_SR_INIT;
                                o_cmd.rd_en = 1'b1;
                                n_state     = S_SR_CMP;
                            end
                        end
                        ACT_REVERSE: begin
                            if (i_flags.rv_none) begin
                                n_state = S_FINISH;
                            end else begin
                                o_cmd.ptr   = PTR_RV_INIT;
                                o_cmd.rd_en = 1'b1;
                                n_state     = S_RV_WLO;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_INS_MV: begin
                o_cmd.wr = WR_INS_MOVE;
                if (i_flags.ins_last) begin
                    n_state = S_INS_PUT;
                end else begin
                    o_cmd.ptr   = PTR_DEC;
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_INS_PUT: begin
                o_cmd.wr = WR_INS_PUT;
                n_state  = S_FINISH;
            end
            S_RM_MV: begin
                o_cmd.wr = WR_RM_MOVE;
                if (i_flags.rm_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.ptr   = PTR_INC;
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_SR_CMP: begin
                priority if (i_flags.sr_match) begin
                    o_cmd.set_found = 1'b1;
                    n_state         = S_FINISH;
                end else if (i_flags.sr_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.ptr   = PTR_INC;
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_RV_WLO: begin
                o_cmd.wr = WR_RV_LO;
                n_state  = S_RV_WHI;
            end
            S_RV_WHI: begin
                o_cmd.wr = WR_RV_HI;
                if (i_flags.rv_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.ptr   = PTR_RV_STEP;
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_RV_WLO;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
                n_busy       = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- sv/bole_chk.sv -----
// Port-level checker for the list engine, bound to the top level.
// Depends on bole_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bole_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic                          o_found,
    input logic [bole_pkg::STATUS_W-1:0] o_status
);
    import bole_pkg::*;

    `BOLE_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> (!busy && !o_done), "reset left engine active")
    `BOLE_ASSERT(a_take_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted request not busy")
    `BOLE_ASSERT(a_done_ends_busy, i_clk, i_rst_n, o_done |-> (!busy && $past(busy)), "strobe not at end of busy")
    `BOLE_ASSERT(a_done_single, i_clk, i_rst_n, o_done |=> !o_done, "result strobe longer than one cycle")
    `BOLE_ASSERT(a_found_ok, i_clk, i_rst_n, (o_done && o_found) |-> (o_status == ST_OK), "found with bad status")

endmodule

bind bounded_ordered_list_engine_core bole_chk u_chk (.*);
